### hdl/mntr_pkg.sv
package mntr_pkg;

  localparam int NOTES        = 128;
  localparam int NOTE_W       = $clog2(NOTES);
  localparam int TRIGGERS_DEF = 8;
  localparam int QDEPTH       = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_IN_CHANNEL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OMNI        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_IN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PROGCHANGE  = 3'd5;

  localparam logic [1:0] OP_BYTE      = 2'd0;
  localparam logic [1:0] OP_MAP_WRITE = 2'd1;
  localparam logic [1:0] OP_SYNC_OFF  = 2'd2;
  localparam logic [1:0] OP_NONE      = 2'd3;

  localparam logic [7:0] MIDI_CLOCK    = 8'hF8;
  localparam logic [7:0] MIDI_START    = 8'hFA;
  localparam logic [7:0] MIDI_CONTINUE = 8'hFB;
  localparam logic [7:0] MIDI_STOP     = 8'hFC;
  localparam logic [7:0] MIDI_SYSTEM   = 8'hF0;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_PROGRAM  = 4'hC;

  localparam logic [2:0] EV_NONE  = 3'd0;
  localparam logic [2:0] EV_CLOCK = 3'd1;
  localparam logic [2:0] EV_FIRST = 3'd2;
  localparam logic [2:0] EV_START = 3'd3;
  localparam logic [2:0] EV_STOP  = 3'd4;

  typedef enum logic [1:0] {
    CMD_RESULT,
    CMD_MAP_WRITE,
    CMD_LOOKUP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [2:0]        sync_event;
    logic              activity;
    logic              fwd_valid;
    logic [7:0]        fwd_status;
    logic [6:0]        fwd_data;
    logic              prog_valid;
    logic [6:0]        prog_number;
    logic [NOTE_W-1:0] note;
    logic [7:0]        map_trig;
    logic [6:0]        map_len;
  } cmd_t;

endpackage

### hdl/mntr_front.sv
module mntr_front import mntr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  input  logic [1:0]            opcode,
  input  logic [7:0]            midi_byte,
  input  logic [6:0]            map_note,
  input  logic [7:0]            map_trigger,
  input  logic [6:0]            map_length,
  output cmd_t                  cmd
);

  typedef enum logic [1:0] {
    SYNC_OFF,
    SYNC_STARTED,
    SYNC_RUNNING,
    SYNC_STOPPED
  } sync_mode_t;

  logic [3:0] in_channel;
  logic       omni;
  logic       sync_enable;
  logic       allow_in;
  logic       capture_mode;
  logic       progchange_enable;

  logic [7:0]  running_status, running_status_next;
  logic [1:0]  bytes_remaining, bytes_remaining_next;
  logic [6:0]  held_note, held_note_next;
  sync_mode_t  sync_mode, sync_mode_next;

  logic chan_ok;

  assign chan_ok = (running_status[3:0] == in_channel) || omni || capture_mode;

  always_comb begin
    running_status_next  = running_status;
    bytes_remaining_next = bytes_remaining;
    held_note_next       = held_note;
    sync_mode_next       = sync_mode;
    cmd                  = '0;
    cmd.kind             = CMD_RESULT;
    cmd.note             = map_note;
    cmd.map_trig         = map_trigger;
    cmd.map_len          = map_length;
    case (opcode)
      OP_BYTE: begin
        if (midi_byte >= MIDI_CLOCK) begin
          // realtime words never touch the parser
          if (sync_enable && allow_in) begin
            case (midi_byte)
              MIDI_CLOCK: begin
                if (sync_mode == SYNC_RUNNING) begin
                  cmd.sync_event = EV_CLOCK;
                end else if (sync_mode == SYNC_STARTED) begin
                  sync_mode_next = SYNC_RUNNING;
                  cmd.sync_event = EV_FIRST;
                end
              end
              MIDI_START, MIDI_CONTINUE: begin
                if (sync_mode == SYNC_OFF) begin
                  sync_mode_next = SYNC_STARTED;
                  cmd.sync_event = EV_START;
                end
              end
              MIDI_STOP: begin
                if (sync_mode == SYNC_RUNNING || sync_mode == SYNC_STARTED) begin
                  sync_mode_next = SYNC_STOPPED;
                  cmd.sync_event = EV_STOP;
                end
              end
              default: ;
            endcase
          end
        end else if (midi_byte >= MIDI_SYSTEM) begin
          running_status_next = '0;
        end else if (midi_byte[7]) begin
          running_status_next = midi_byte;
          if (midi_byte[7:4] == KIND_NOTE_ON) begin
            bytes_remaining_next = 2'd2;
          end else if (midi_byte[7:4] == KIND_PROGRAM && progchange_enable) begin
            bytes_remaining_next = 2'd1;
          end else begin
            bytes_remaining_next = 2'd0;
          end
        end else if (bytes_remaining == 2'd2) begin
          held_note_next       = midi_byte[6:0];
          bytes_remaining_next = 2'd1;
        end else if (bytes_remaining == 2'd1) begin
          if (running_status[7:4] == KIND_NOTE_ON) begin
            // rearm for the next note under running status
            bytes_remaining_next = 2'd2;
            if (midi_byte[6:0] != 7'd0 && chan_ok) begin
              cmd.activity = 1'b1;
              if (!capture_mode) begin
                if (allow_in) begin
                  cmd.kind = CMD_LOOKUP;
                  cmd.note = held_note;
                end
              end else begin
                cmd.fwd_valid  = 1'b1;
                cmd.fwd_status = running_status;
                cmd.fwd_data   = held_note;
              end
            end
          end else if (running_status[7:4] == KIND_PROGRAM && progchange_enable) begin
            if (chan_ok) begin
              if (!capture_mode) begin
                if (allow_in) begin
                  cmd.prog_valid  = 1'b1;
                  cmd.prog_number = midi_byte[6:0];
                end
              end else begin
                cmd.fwd_valid  = 1'b1;
                cmd.fwd_status = running_status;
                cmd.fwd_data   = midi_byte[6:0];
              end
            end
          end
        end
      end
      OP_MAP_WRITE: begin
        cmd.kind = CMD_MAP_WRITE;
      end
      OP_SYNC_OFF: begin
        sync_mode_next = SYNC_OFF;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_channel        <= '0;
      omni              <= 1'b0;
      sync_enable       <= 1'b0;
      allow_in          <= 1'b1;
      capture_mode      <= 1'b0;
      progchange_enable <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_IN_CHANNEL:  in_channel        <= cfg_data;
        CFG_OMNI:        omni              <= cfg_data[0];
        CFG_SYNC_ENABLE: sync_enable       <= cfg_data[0];
        CFG_ALLOW_IN:    allow_in          <= cfg_data[0];
        CFG_CAPTURE:     capture_mode      <= cfg_data[0];
        CFG_PROGCHANGE:  progchange_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_status  <= '0;
      bytes_remaining <= '0;
      held_note       <= '0;
      sync_mode       <= SYNC_OFF;
    end else if (accept) begin
      running_status  <= running_status_next;
      bytes_remaining <= bytes_remaining_next;
      held_note       <= held_note_next;
      sync_mode       <= sync_mode_next;
    end
  end

endmodule

### hdl/mntr_queue.sv
module mntr_queue import mntr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wdata,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t rdata
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  cmd_t             slots [QDEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QDEPTH));
  assign valid = (count != '0);
  assign rdata = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    bump = (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### hdl/mntr_back.sv
module mntr_back import mntr_pkg::*; #(
  parameter int TRIGGERS = TRIGGERS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_t       q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] sync_event,
  output logic       trigger_fire,
  output logic [2:0] trigger_index,
  output logic [6:0] trigger_length,
  output logic       unused_trigger,
  output logic       activity,
  output logic       forward_valid,
  output logic [7:0] forward_status,
  output logic [6:0] forward_data,
  output logic       program_valid,
  output logic [6:0] program_number
);

  typedef struct packed {
    logic [7:0] trig;
    logic [6:0] len;
  } map_entry_t;

  map_entry_t map_mem [NOTES];
  map_entry_t rd;
  cmd_t       stage;
  logic       stage_valid;
  logic       advance;
  logic       hit;

  assign advance = stage_valid && (!out_valid || !out_stall);
  assign q_pop   = q_valid && (!stage_valid || advance);
  assign hit     = (rd.trig < 8'(TRIGGERS));

  // map writes and lookups leave the queue in order, so a lookup sees every earlier write
  always_ff @(posedge clk) begin
    if (q_pop && q_head.kind == CMD_MAP_WRITE) begin
      map_mem[q_head.note] <= '{trig: q_head.map_trig, len: q_head.map_len};
    end
    if (q_pop && q_head.kind == CMD_LOOKUP) begin
      rd <= map_mem[q_head.note];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (q_pop) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      stage <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sync_event     <= stage.sync_event;
      activity       <= stage.activity;
      forward_valid  <= stage.fwd_valid;
      forward_status <= stage.fwd_status;
      forward_data   <= stage.fwd_data;
      program_valid  <= stage.prog_valid;
      program_number <= stage.prog_number;
      trigger_fire   <= 1'b0;
      trigger_index  <= '0;
      trigger_length <= '0;
      unused_trigger <= 1'b0;
      if (stage.kind == CMD_LOOKUP) begin
        if (hit) begin
          trigger_fire   <= 1'b1;
          trigger_index  <= rd.trig[2:0];
          trigger_length <= rd.len;
        end else begin
          unused_trigger <= 1'b1;
        end
      end
    end
  end

endmodule

### hdl/midi_note_trigger_receiver_core.sv
// MIDI note trigger receiver: one word per cycle in while in_stall is low, one
// result word per accepted word out. The front end parses running status and sync
// and hands a command to a two-entry queue; the back end reads the 128-entry note
// map (registered read) and loads the output register. A word goes through the
// queue slot (written at the accepting edge), the map read stage and the output
// register; out_stall can hold it. Map entries must be written before a note-on
// that hits them; the user must write configuration while idle (not enforced).
module midi_note_trigger_receiver_core import mntr_pkg::*; #(
  parameter int TRIGGERS = TRIGGERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            opcode,
  input  logic [7:0]            midi_byte,
  input  logic [6:0]            map_note,
  input  logic [7:0]            map_trigger,
  input  logic [6:0]            map_length,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            sync_event,
  output logic                  trigger_fire,
  output logic [2:0]            trigger_index,
  output logic [6:0]            trigger_length,
  output logic                  unused_trigger,
  output logic                  activity,
  output logic                  forward_valid,
  output logic [7:0]            forward_status,
  output logic [6:0]            forward_data,
  output logic                  program_valid,
  output logic [6:0]            program_number
);

  cmd_t front_cmd;
  cmd_t q_head;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  mntr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .opcode      (opcode),
    .midi_byte   (midi_byte),
    .map_note    (map_note),
    .map_trigger (map_trigger),
    .map_length  (map_length),
    .cmd         (front_cmd)
  );

  mntr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata (front_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_head)
  );

  mntr_back #(
    .TRIGGERS (TRIGGERS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sync_event     (sync_event),
    .trigger_fire   (trigger_fire),
    .trigger_index  (trigger_index),
    .trigger_length (trigger_length),
    .unused_trigger (unused_trigger),
    .activity       (activity),
    .forward_valid  (forward_valid),
    .forward_status (forward_status),
    .forward_data   (forward_data),
    .program_valid  (program_valid),
    .program_number (program_number)
  );

  a_fire_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid && trigger_fire |-> activity && !unused_trigger && !forward_valid)
    else $error("trigger fired without a clean note-on result");

  a_program_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && program_valid |-> !forward_valid && !trigger_fire && !activity &&
      sync_event == EV_NONE)
    else $error("program change mixed with another event");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present right after reset");

endmodule
